// ===== sv/multichannel_terminal_rx_latch_macros.svh =====
// Assertion macros used by the terminal top-level RTL file.
`ifndef MULTICHANNEL_TERMINAL_RX_LATCH_MACROS_SVH
`define MULTICHANNEL_TERMINAL_RX_LATCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define MTRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== sv/mtrl_pkg.sv =====
// Types and constants of the multichannel terminal.
`timescale 1ns / 1ps
package mtrl_pkg;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CHSEL_W  = 3;
  localparam int LEVEL_W  = 3;
  localparam int MASK_W   = 8;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RX_LATCHED = 2'd0,
    RX_DROPPED = 2'd1,
    RX_REFUSED = 2'd2,
    RX_NONE    = 2'd3
  } rx_outcome_e;

  typedef enum logic [1:0] {
    CFG_VECTOR_BASE = 2'd0,
    CFG_PRIO_LEVEL  = 2'd1
  } cfg_reg_e;

  localparam logic [7:0] OFF_STATUS = 8'h00;
  localparam logic [7:0] OFF_RXDATA = 8'h02;
  localparam logic [7:0] OFF_TXDATA = 8'h04;

  localparam logic [7:0] ST_RX_READY = 8'h01;
  localparam logic [7:0] ST_TX_EMPTY = 8'h02;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0]         RESET_VECTOR_BASE = 8'd70;
  localparam logic [LEVEL_W-1:0] RESET_PRIO_LEVEL  = 3'd4;

  typedef struct packed {
    logic             up;
    logic [BYTE_W-1:0] vector;
  } irq_t;

endpackage

// ===== sv/mtrl_if.sv =====
// Request, result and configuration channel interfaces of the terminal.
`timescale 1ns / 1ps
interface mtrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [10:0] address;
  logic [7:0]  data_in;

  modport source (output valid, func, address, data_in, input ready);
  modport sink   (input valid, func, address, data_in, output ready);
endinterface

interface mtrl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [2:0] tx_channel;
  logic [7:0] tx_byte;
  logic [1:0] rx_outcome;
  logic [7:0] rx_free_mask;
  logic [2:0] irq_level;
  logic [7:0] irq_vector;

  modport source (output valid, read_data, tx_valid, tx_channel, tx_byte, rx_outcome,
                  rx_free_mask, irq_level, irq_vector, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_channel, tx_byte, rx_outcome,
                  rx_free_mask, irq_level, irq_vector, output ready);
endinterface

interface mtrl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mtrl_irq_enc.sv =====
// Priority encoder: lowest ready channel picks the interrupt vector.
`timescale 1ns / 1ps
module mtrl_irq_enc
  import mtrl_pkg::*;
#(
  parameter int NUM_CH = 8
) (
  input  logic [NUM_CH-1:0] ready_flags,
  input  logic [7:0]        vector_base,
  output irq_t              irq
);

  always_comb begin
    irq.up     = 1'b0;
    irq.vector = '0;
    // scan from the top so the lowest ready channel wins
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (ready_flags[i]) begin
        irq.up     = 1'b1;
        irq.vector = vector_base + 8'(i);
      end
    end
  end

endmodule

// ===== sv/multichannel_terminal_rx_latch.sv =====
// Top level of the eight-channel byte terminal with receive latches.
//
//   channel  | dir | payload                                  | accepted when
//   cfg      | in  | index, data                              | valid & ready
//   item     | in  | func, address, data_in                   | valid & ready
//   result   | out | read_data, tx_*, rx_outcome, mask, irq_* | valid & ready
//
// One request per cycle; the channel state update and the priority encode of
// the ready flags run in the cycle a request is taken; its result enters the
// result register in the cycle after. A request is taken while the result
// register is empty or being drained, so a stalled sink holds the request side.
// Synchronous reset clears the latches and flags; cfg is always ready.
`timescale 1ns / 1ps
`include "multichannel_terminal_rx_latch_macros.svh"
module multichannel_terminal_rx_latch
  import mtrl_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input logic        clk,
  input logic        rst,
  mtrl_cfg_if.sink   cfg,
  mtrl_in_if.sink    item,
  mtrl_out_if.source result
);

  // channels beyond eight cannot be addressed by the three channel bits
  localparam int NCH  = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int CH_W = $clog2(NCH);

  logic [7:0]         vec_base;
  logic [LEVEL_W-1:0] prio_level;

  logic [7:0]    rx_latch [NCH];
  logic [NCH-1:0] rdy;
  logic [NCH-1:0] prev_cr;

  logic [NCH-1:0] rdy_next;
  logic [NCH-1:0] prev_cr_next;
  logic           latch_we;

  logic            acc;
  logic [2:0]      ch;
  logic [7:0]      off;
  logic            present;
  logic [CH_W-1:0] ch_idx;

  logic [7:0]     read_data_next;
  logic           tx_valid_next;
  logic [2:0]     tx_channel_next;
  logic [7:0]     tx_byte_next;
  rx_outcome_e    outcome_next;
  logic [7:0]     mask_next;
  irq_t           irq;

  assign cfg.ready  = 1'b1;
  assign item.ready = !result.valid || result.ready;
  assign acc        = item.valid && item.ready;

  assign ch      = item.address[10:8];
  assign off     = item.address[7:0];
  assign present = (int'(ch) < NUM_CHANNELS);
  assign ch_idx  = ch[CH_W-1:0];

  always_comb begin
    rdy_next        = rdy;
    prev_cr_next    = prev_cr;
    latch_we        = 1'b0;
    read_data_next  = '0;
    tx_valid_next   = 1'b0;
    tx_channel_next = '0;
    tx_byte_next    = '0;
    outcome_next    = RX_NONE;
    case (func_e'(item.func))
      FUNC_READ: begin
        if (present) begin
          if (off == OFF_STATUS) begin
            read_data_next = (rdy[ch_idx] ? ST_RX_READY : 8'h00) | ST_TX_EMPTY;
          end else if (off == OFF_RXDATA) begin
            read_data_next   = rx_latch[ch_idx];
            rdy_next[ch_idx] = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        if (present && off == OFF_TXDATA) begin
          tx_valid_next   = 1'b1;
          tx_channel_next = ch;
          tx_byte_next    = item.data_in;
        end
      end
      FUNC_RX: begin
        if (!present || rdy[ch_idx]) begin
          outcome_next = RX_REFUSED;
        end else if (item.data_in == CHAR_LF && prev_cr[ch_idx]) begin
          prev_cr_next[ch_idx] = 1'b0;
          outcome_next         = RX_DROPPED;
        end else begin
          prev_cr_next[ch_idx] = (item.data_in == CHAR_CR);
          rdy_next[ch_idx]     = 1'b1;
          latch_we             = 1'b1;
          outcome_next         = RX_LATCHED;
        end
      end
      default: begin
      end
    endcase
    mask_next          = '0;
    mask_next[NCH-1:0] = ~rdy_next;
  end

  mtrl_irq_enc #(
    .NUM_CH(NCH)
  ) u_irq_enc (
    .ready_flags(rdy_next),
    .vector_base(vec_base),
    .irq        (irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_base   <= RESET_VECTOR_BASE;
      prio_level <= RESET_PRIO_LEVEL;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        CFG_VECTOR_BASE: vec_base   <= cfg.data;
        CFG_PRIO_LEVEL:  prio_level <= cfg.data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rdy     <= '0;
      prev_cr <= '0;
      for (int i = 0; i < NCH; i++) begin
        rx_latch[i] <= '0;
      end
    end else if (acc) begin
      rdy     <= rdy_next;
      prev_cr <= prev_cr_next;
      if (latch_we) begin
        rx_latch[ch_idx] <= item.data_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (acc) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result payload: hold while stalled, load on every taken request
  always_ff @(posedge clk) begin
    if (acc) begin
      result.read_data    <= read_data_next;
      result.tx_valid     <= tx_valid_next;
      result.tx_channel   <= tx_channel_next;
      result.tx_byte      <= tx_byte_next;
      result.rx_outcome   <= outcome_next;
      result.rx_free_mask <= mask_next;
      result.irq_level    <= irq.up ? prio_level : '0;
      result.irq_vector   <= irq.up ? irq.vector : '0;
    end
  end

  `MTRL_ASSERT_NEXT(a_acc_gives_result, clk, rst, acc, result.valid)
  `MTRL_ASSERT_NOW(a_tx_not_rx, clk, rst, result.valid && result.tx_valid, result.rx_outcome == RX_NONE)
  `MTRL_ASSERT_NOW(a_mask_tracks_flags, clk, rst, result.valid, result.rx_free_mask[NCH-1:0] == ~rdy)
  `MTRL_ASSERT_NOW(a_irq_needs_ready, clk, rst, result.valid && result.irq_level != 3'd0, !(&result.rx_free_mask[NCH-1:0]))

endmodule
